// ===== hw/rtl/tdci_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-of-day color interpolator package
// Shared widths, slot codes, payload structs and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tdci_pkg;

  localparam int HourW      = 16;  // input hour, 1/256 hour, signed
  localparam int ColorW     = 24;  // packed RGB slot color
  localparam int ChanW      = 8;   // one color channel
  localparam int NumChan    = 3;
  localparam int NumSlots   = 6;
  localparam int NumPoints  = 8;
  localparam int CfgW       = 13;  // sunrise and sunset register width
  localparam int CfgIdxW    = 2;
  localparam int SlotW      = 3;
  localparam int WeightW    = 17;  // Q1.16
  localparam int HourModW   = 13;  // wrapped hour 0..6143
  localparam int H2W        = 14;  // wrapped hour in 1/512 hour
  localparam int PtW        = 15;  // control points in 1/512 hour
  localparam int DiffW      = 16;  // signed differences of points
  localparam int QuoW       = 16;  // quotient bits below the clamp
  localparam int DivStages  = 4;
  localparam int DivStepBits = QuoW / DivStages;
  localparam int WrapW      = 17;

  localparam logic [CfgIdxW-1:0] CfgSunrise = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSunset  = 2'd1;

  localparam logic [CfgW-1:0]    SunriseReset = 13'd1536;
  localparam logic [CfgW-1:0]    SunsetReset  = 13'd4608;

  // Six days of bias make every signed input hour non-negative.
  localparam logic [WrapW-1:0]   WrapBias   = 17'd36864;
  localparam logic [PtW-1:0]     NoonUnits  = 15'd3072;
  localparam logic [PtW-1:0]     DayUnits   = 15'd6144;
  localparam logic [PtW-1:0]     DayUnits2  = 15'd12288;
  localparam logic [WeightW-1:0] WeightOne  = 17'd65536;
  localparam logic [WeightW-1:0] WeightZero = 17'd0;

  typedef enum logic [SlotW-1:0] {
    SlotMidnight = 3'd0,
    SlotSunrise  = 3'd1,
    SlotDay      = 3'd2,
    SlotNoon     = 3'd3,
    SlotSunset   = 3'd4,
    SlotNight    = 3'd5
  } tdci_slot_e;

  typedef struct packed {
    logic signed [HourW-1:0] hour_of_day;
    logic [ColorW-1:0]       midnight_color;
    logic [ColorW-1:0]       sunrise_color;
    logic [ColorW-1:0]       day_color;
    logic [ColorW-1:0]       noon_color;
    logic [ColorW-1:0]       sunset_color;
    logic [ColorW-1:0]       night_color;
  } tdci_in_t;

  typedef struct packed {
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [SlotW-1:0]   from_slot;
    logic [SlotW-1:0]   to_slot;
    logic [WeightW-1:0] blend_weight;
  } tdci_out_t;

  typedef logic [NumSlots-1:0][ColorW-1:0] tdci_colors_t;

  // Segment data that rides along the weight divider.
  typedef struct packed {
    logic [ColorW-1:0] ca;
    logic [ColorW-1:0] cb;
    tdci_slot_e        from_slot;
    tdci_slot_e        to_slot;
  } tdci_side_t;

  // Residue modulo 3 of a 6-bit value, by folding base-4 digits.
  function automatic logic [1:0] tdci_mod3(input logic [5:0] q);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, q[1:0]} + {2'b00, q[3:2]} + {2'b00, q[5:4]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

  // Slot shown at each control point of the day curve.
  function automatic tdci_slot_e tdci_point_slot(input logic [2:0] idx);
    tdci_slot_e s;
    unique case (idx)
      3'd0:    s = SlotMidnight;
      3'd1:    s = SlotSunrise;
      3'd2:    s = SlotDay;
      3'd3:    s = SlotNoon;
      3'd4:    s = SlotDay;
      3'd5:    s = SlotSunset;
      3'd6:    s = SlotNight;
      default: s = SlotMidnight;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdci_divider.sv =====
// ----------------------------------------------------------------------------
// Weight divider
// Pipelined restoring divider for the blend weight, four quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdci_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [tdci_pkg::PtW-1:0]     rem_i,
  input  wire logic [tdci_pkg::PtW-1:0]     span_i,
  input  wire logic                         zero_i,
  input  wire logic                         full_i,
  input  wire tdci_pkg::tdci_side_t         side_i,
  output logic                              valid_o,
  output logic [tdci_pkg::WeightW-1:0]      weight_o,
  output tdci_pkg::tdci_side_t              side_o
);
  import tdci_pkg::*;

  localparam int Last = DivStages - 1;

  logic [DivStages-1:0]                valid_q;
  logic [DivStages-1:0][PtW-1:0]       rem_q;
  logic [DivStages-1:0][QuoW-1:0]      quo_q;
  logic [DivStages-1:0][PtW-1:0]       span_q;
  logic [DivStages-1:0]                zero_q;
  logic [DivStages-1:0]                full_q;
  tdci_side_t [DivStages-1:0]          side_q;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             vin;
    logic [PtW-1:0]   rin;
    logic [QuoW-1:0]  qin;
    logic [PtW-1:0]   sin;
    logic             zin;
    logic             fin;
    tdci_side_t       din;
    logic [PtW-1:0]   rem_d;
    logic [QuoW-1:0]  quo_d;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rem_i;
      assign qin = '0;
      assign sin = span_i;
      assign zin = zero_i;
      assign fin = full_i;
      assign din = side_i;
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign rin = rem_q[s-1];
      assign qin = quo_q[s-1];
      assign sin = span_q[s-1];
      assign zin = zero_q[s-1];
      assign fin = full_q[s-1];
      assign din = side_q[s-1];
    end

    // The remainder stays below the span, so the doubled value fits one extra bit.
    always_comb begin
      logic [PtW:0]    t;
      logic [PtW-1:0]  r;
      logic [QuoW-1:0] q;
      r = rin;
      q = qin;
      for (int k = 0; k < DivStepBits; k++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, sin}) begin
          t = t - {1'b0, sin};
          q = {q[QuoW-2:0], 1'b1};
        end else begin
          q = {q[QuoW-2:0], 1'b0};
        end
        r = t[PtW-1:0];
      end
      rem_d = r;
      quo_d = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
      span_q[s] <= sin;
      zero_q[s] <= zin;
      full_q[s] <= fin;
      side_q[s] <= din;
    end
  end

  always_comb begin
    priority if (full_q[Last]) begin
      weight_o = WeightOne;
    end else if (zero_q[Last]) begin
      weight_o = WeightZero;
    end else begin
      weight_o = {1'b0, quo_q[Last]};
    end
  end

  assign valid_o = valid_q[Last];
  assign side_o  = side_q[Last];

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[Last] && !zero_q[Last] && !full_q[Last] |-> rem_q[Last] < span_q[Last])
    else $error("divider remainder not below span");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> weight_o <= WeightOne)
    else $error("blend weight above one");

  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##DivStages valid_o)
    else $error("divider lost an item");

endmodule

`default_nettype wire

// ===== hw/rtl/tdci_mixer.sv =====
// ----------------------------------------------------------------------------
// Channel mixer
// Blends the two segment colors per channel with the Q1.16 weight, two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdci_mixer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [tdci_pkg::WeightW-1:0] weight_i,
  input  wire tdci_pkg::tdci_side_t         side_i,
  output logic                              valid_o,
  output tdci_pkg::tdci_out_t               result_o
);
  import tdci_pkg::*;

  localparam int ProdW = ChanW + 1 + WeightW + 1;

  logic                                 m1_valid_q;
  logic [NumChan-1:0][ProdW-1:0]        m1_prod_q;
  logic [NumChan-1:0][ChanW-1:0]        m1_base_q;
  tdci_slot_e                           m1_from_q;
  tdci_slot_e                           m1_to_q;
  logic [WeightW-1:0]                   m1_weight_q;

  logic                                 out_valid_q;
  tdci_out_t                            out_q;
  logic [NumChan-1:0][ChanW-1:0]        chan_d;

  // a*(1-w) + b*w is rewritten as a + (b-a)*w: one multiplier per channel.
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    logic [ChanW-1:0]        a;
    logic [ChanW-1:0]        b;
    logic signed [ChanW:0]   diff;
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] sum;

    assign a    = side_i.ca[c*ChanW +: ChanW];
    assign b    = side_i.cb[c*ChanW +: ChanW];
    assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
    assign prod = diff * $signed({1'b0, weight_i});

    always_ff @(posedge clk_i) begin
      m1_prod_q[c] <= prod;
      m1_base_q[c] <= a;
    end

    // Base shifted up by 16 with the half LSB for rounding in the low bits.
    assign sum = $signed({{(ProdW-ChanW-16){1'b0}}, m1_base_q[c], 16'h8000})
               + $signed(m1_prod_q[c]);
    assign chan_d[c] = sum[16 +: ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m1_valid_q  <= valid_i;
      out_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_from_q   <= side_i.from_slot;
    m1_to_q     <= side_i.to_slot;
    m1_weight_q <= weight_i;
    out_q.red          <= chan_d[2];
    out_q.green        <= chan_d[1];
    out_q.blue         <= chan_d[0];
    out_q.from_slot    <= m1_from_q;
    out_q.to_slot      <= m1_to_q;
    out_q.blend_weight <= m1_weight_q;
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##2 valid_o)
    else $error("mixer lost an item");

  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && weight_i == WeightZero |-> ##2 result_o.blue == $past(side_i.ca[7:0], 2))
    else $error("zero weight must give the start color");

  a_weight_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && weight_i == WeightOne |-> ##2 result_o.red == $past(side_i.cb[23:16], 2))
    else $error("full weight must give the end color");

endmodule

`default_nettype wire

// ===== hw/rtl/time_of_day_color_interpolator.sv =====
// ----------------------------------------------------------------------------
// Time-of-day color interpolator
// Wraps the hour, finds its segment on the day curve and blends two slot colors.
// ----------------------------------------------------------------------------
// The result strobe follows the start transfer through three front stages,
//   four weight divider stages and two mixer stages.
// Throughput: one item per cycle; busy_o never rises.
// Results cannot be held off, so the pipeline advances every cycle.
// Reset clears all valid bits and loads sunrise 6 h and sunset 18 h.
`default_nettype none

module time_of_day_color_interpolator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire tdci_pkg::tdci_in_t            data_i,
  output logic                               result_valid_o,
  output tdci_pkg::tdci_out_t                result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tdci_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tdci_pkg::CfgW-1:0]     cfg_data_i
);
  import tdci_pkg::*;

  logic [CfgW-1:0] sunrise_q;
  logic [CfgW-1:0] sunset_q;

  logic [NumPoints-1:0][PtW-1:0] pts;

  // Stage 1: wrapped hour.
  logic [WrapW-1:0]    wrap_sum;
  logic [HourModW-1:0] hour_d;
  tdci_colors_t        colors_d;
  logic                s1_valid_q;
  logic [HourModW-1:0] s1_hour_q;
  tdci_colors_t        s1_colors_q;

  // Stage 2: segment search.
  logic [H2W-1:0]      h2;
  logic [2:0]          upper_d;
  logic                s2_valid_q;
  logic [2:0]          s2_upper_q;
  logic [H2W-1:0]      s2_h2_q;
  tdci_colors_t        s2_colors_q;

  // Stage 3: span, numerator and clamp flags.
  logic [2:0]              lower;
  logic [PtW-1:0]          lo_pt;
  logic [PtW-1:0]          hi_pt;
  logic signed [DiffW-1:0] num;
  logic signed [DiffW-1:0] span_raw;
  logic [PtW-1:0]          span_d;
  logic                    zero_d;
  logic                    full_d;
  tdci_side_t              side_d;
  logic                    s3_valid_q;
  logic [PtW-1:0]          s3_rem_q;
  logic [PtW-1:0]          s3_span_q;
  logic                    s3_zero_q;
  logic                    s3_full_q;
  tdci_side_t              s3_side_q;

  logic                div_valid;
  logic [WeightW-1:0]  div_weight;
  tdci_side_t          div_side;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sunrise_q <= SunriseReset;
      sunset_q  <= SunsetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSunrise: sunrise_q <= cfg_data_i;
        CfgSunset:  sunset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control points in 1/512 hour; they need not be in order.
  always_comb begin
    pts[0] = '0;
    pts[1] = {1'b0, sunrise_q, 1'b0};
    pts[2] = {2'b00, sunrise_q} + NoonUnits;
    pts[3] = DayUnits;
    pts[4] = {2'b00, sunset_q} + NoonUnits;
    pts[5] = {1'b0, sunset_q, 1'b0};
    pts[6] = {2'b00, sunset_q} + DayUnits;
    pts[7] = DayUnits2;
  end

  // A day is 3 * 2048 units: the low 11 bits pass, the upper part is taken mod 3.
  assign wrap_sum = {data_i.hour_of_day[HourW-1], data_i.hour_of_day} + WrapBias;
  assign hour_d   = {tdci_mod3(wrap_sum[WrapW-1:11]), wrap_sum[10:0]};

  always_comb begin
    colors_d[SlotMidnight] = data_i.midnight_color;
    colors_d[SlotSunrise]  = data_i.sunrise_color;
    colors_d[SlotDay]      = data_i.day_color;
    colors_d[SlotNoon]     = data_i.noon_color;
    colors_d[SlotSunset]   = data_i.sunset_color;
    colors_d[SlotNight]    = data_i.night_color;
  end

  assign h2 = {s1_hour_q, 1'b0};

  // The first point at or above the hour ends the segment.
  always_comb begin
    upper_d = 3'd7;
    for (int i = NumPoints - 1; i >= 1; i--) begin
      if ({1'b0, h2} <= pts[i]) begin
        upper_d = 3'(i);
      end
    end
  end

  assign lower    = s2_upper_q - 3'd1;
  assign lo_pt    = pts[lower];
  assign hi_pt    = pts[s2_upper_q];
  assign num      = $signed({2'b00, s2_h2_q}) - $signed({1'b0, lo_pt});
  assign span_raw = $signed({1'b0, hi_pt}) - $signed({1'b0, lo_pt});
  assign span_d   = (span_raw[DiffW-1] || span_raw == '0) ? PtW'(1) : span_raw[PtW-1:0];
  assign zero_d   = num[DiffW-1] || num == '0;
  // A numerator at or past the span saturates the weight at one.
  assign full_d   = !zero_d && (num[PtW-1:0] >= span_d);

  always_comb begin
    side_d.from_slot = tdci_point_slot(lower);
    side_d.to_slot   = tdci_point_slot(s2_upper_q);
    side_d.ca        = s2_colors_q[side_d.from_slot];
    side_d.cb        = s2_colors_q[side_d.to_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hour_q   <= hour_d;
    s1_colors_q <= colors_d;
    s2_upper_q  <= upper_d;
    s2_h2_q     <= h2;
    s2_colors_q <= s1_colors_q;
    s3_rem_q    <= num[PtW-1:0];
    s3_span_q   <= span_d;
    s3_zero_q   <= zero_d;
    s3_full_q   <= full_d;
    s3_side_q   <= side_d;
  end

  tdci_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid_q),
    .rem_i    (s3_rem_q),
    .span_i   (s3_span_q),
    .zero_i   (s3_zero_q),
    .full_i   (s3_full_q),
    .side_i   (s3_side_q),
    .valid_o  (div_valid),
    .weight_o (div_weight),
    .side_o   (div_side)
  );

  tdci_mixer u_mixer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .weight_i (div_weight),
    .side_i   (div_side),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  a_item_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##9 result_valid_o)
    else $error("accepted item produced no result");

  a_upper_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_upper_q != 3'd0)
    else $error("segment end point must follow the hour-zero point");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.from_slot <= SlotNight && result_o.to_slot <= SlotNight)
    else $error("slot code out of range");

endmodule

`default_nettype wire

// ===== dv/time_of_day_color_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// Time-of-day color interpolator testbench
// Drives hours and slot color sets through the command port and checks every
// blended color, segment and weight against a known result or the day curve predictor.
// A short directed table is followed by random phases, each under its own
// sunrise and sunset setting, including out-of-order and out-of-range ones.
// ----------------------------------------------------------------------------
module time_of_day_color_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdci_pkg::*;

  localparam int NumPhases      = 11;
  localparam int NumFixedPhases = 7;
  localparam int ItemsPerPhase  = 50;
  localparam int NumDirRows     = 20;
  localparam int MaxReported    = 10;
  localparam int DrainCycles    = 20;
  localparam int HourDay        = 6144;
  localparam int HourNoon       = 3072;

  // The two upper register indexes decode to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  localparam logic [1:0] SetPalette  = 2'd0;
  localparam logic [1:0] SetExtremes = 2'd1;
  localparam logic [1:0] SetAllOnes  = 2'd2;
  localparam logic [1:0] SetStripes  = 2'd3;

  localparam logic [ColorW-1:0] SetColor [4][NumSlots] = '{
    '{24'h102030, 24'hF08040, 24'h80C0FF, 24'hFFFFE0, 24'hFF4010, 24'h000040},
    '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555}
  };

  localparam tdci_slot_e CurveSlot [NumPoints] = '{
    SlotMidnight, SlotSunrise, SlotDay, SlotNoon, SlotDay, SlotSunset, SlotNight,
    SlotMidnight
  };

  localparam logic [CfgW-1:0] PhaseSunrise [NumFixedPhases] = '{
    13'd0, 13'd6144, 13'd8191, 13'd0, 13'd3000, 13'd1536, 13'd6144
  };
  localparam logic [CfgW-1:0] PhaseSunset [NumFixedPhases] = '{
    13'd6144, 13'd0, 13'd8191, 13'd0, 13'd1000, 13'd4608, 13'd6144
  };

  typedef struct packed {
    logic signed [HourW-1:0] hour;
    logic [1:0]              cset;
    logic                    known;
    tdci_out_t               result;
  } dir_row_t;

  // Rows with a known result sit on control points or exact midpoints under
  // the reset setting; the rest go through the predictor.
  localparam dir_row_t DirTab [NumDirRows] = '{
    '{16'd0,     SetPalette,  1'b1, '{8'h10, 8'h20, 8'h30, SlotMidnight, SlotSunrise, 17'd0}},
    '{16'd1536,  SetPalette,  1'b1, '{8'hF0, 8'h80, 8'h40, SlotMidnight, SlotSunrise,
                                       17'd65536}},
    '{16'd3072,  SetPalette,  1'b1, '{8'hFF, 8'hFF, 8'hE0, SlotDay, SlotNoon, 17'd65536}},
    '{16'd4608,  SetPalette,  1'b1, '{8'hFF, 8'h40, 8'h10, SlotDay, SlotSunset, 17'd65536}},
    '{16'd5376,  SetPalette,  1'b1, '{8'h00, 8'h00, 8'h40, SlotSunset, SlotNight, 17'd65536}},
    '{16'd6144,  SetPalette,  1'b1, '{8'h10, 8'h20, 8'h30, SlotMidnight, SlotSunrise, 17'd0}},
    '{16'hE800,  SetPalette,  1'b1, '{8'h10, 8'h20, 8'h30, SlotMidnight, SlotSunrise, 17'd0}},
    '{16'd768,   SetExtremes, 1'b1, '{8'h80, 8'h80, 8'h80, SlotMidnight, SlotSunrise,
                                       17'd32768}},
    '{16'd1000,  SetPalette,  1'b0, '0},
    '{16'd2000,  SetPalette,  1'b0, '0},
    '{16'd2800,  SetPalette,  1'b0, '0},
    '{16'd3500,  SetStripes,  1'b0, '0},
    '{16'd4200,  SetPalette,  1'b0, '0},
    '{16'd5000,  SetExtremes, 1'b0, '0},
    '{16'd5800,  SetPalette,  1'b0, '0},
    '{16'h7FFF,  SetAllOnes,  1'b0, '0},
    '{16'h8000,  SetStripes,  1'b0, '0},
    '{16'hFFFF,  SetPalette,  1'b0, '0},
    '{16'h0001,  SetExtremes, 1'b0, '0},
    '{16'hCFC7,  SetPalette,  1'b0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  tdci_in_t           data_i = '0;
  logic               result_valid_o;
  tdci_out_t          result_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgSunrise;
  logic [CfgW-1:0]    cfg_data_i = '0;

  logic [CfgW-1:0] sunrise_reg = SunriseReset;
  logic [CfgW-1:0] sunset_reg = SunsetReset;
  tdci_out_t       pending_colors [$];
  int              mismatch_count = 0;

  time_of_day_color_interpolator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ChanW-1:0] mix_chan(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b,
                                                input int unsigned wt);
    int unsigned v;
    v = a * (32'd65536 - wt) + b * wt + 32'd32768;
    return 8'(v >> 16);
  endfunction

  // Expected blend for one hour under the current sunrise and sunset.
  function automatic tdci_out_t blend_for_hour(input tdci_in_t item);
    int                h, h2, upper, span, num, sr, ss;
    longint            w;
    int                pt [NumPoints];
    logic [ColorW-1:0] slot_color [NumSlots];
    logic [ColorW-1:0] ca, cb;
    tdci_out_t         res;
    sr = int'(sunrise_reg);
    ss = int'(sunset_reg);
    h = int'($signed(item.hour_of_day)) % HourDay;
    if (h < 0) h += HourDay;
    h2 = 2 * h;
    pt = '{0, 2 * sr, sr + HourNoon, 2 * HourNoon, ss + HourNoon, 2 * ss, ss + HourDay,
           2 * HourDay};
    // Descending scan leaves the first point at or above the hour.
    upper = NumPoints - 1;
    for (int i = NumPoints - 1; i >= 1; i--) begin
      if (h2 <= pt[i]) upper = i;
    end
    span = pt[upper] - pt[upper-1];
    if (span < 1) span = 1;
    num = h2 - pt[upper-1];
    if (num <= 0) begin
      w = 0;
    end else begin
      w = (longint'(num) * 65536) / span;
      if (w > 65536) w = 65536;
    end
    slot_color = '{item.midnight_color, item.sunrise_color, item.day_color,
                   item.noon_color, item.sunset_color, item.night_color};
    ca = slot_color[CurveSlot[upper-1]];
    cb = slot_color[CurveSlot[upper]];
    res.red = mix_chan(ca[23:16], cb[23:16], int'(w));
    res.green = mix_chan(ca[15:8], cb[15:8], int'(w));
    res.blue = mix_chan(ca[7:0], cb[7:0], int'(w));
    res.from_slot = CurveSlot[upper-1];
    res.to_slot = CurveSlot[upper];
    res.blend_weight = 17'(w);
    return res;
  endfunction

  // Most hours land next to a control point, in any of the wrapped days.
  function automatic tdci_in_t draw_item();
    int                hour, base, sel;
    logic [ColorW-1:0] col [NumSlots];
    if ($urandom_range(0, 99) < 35) begin
      hour = int'($signed(16'($urandom())));
    end else begin
      case ($urandom_range(0, 7))
        0:       base = 0;
        1:       base = int'(sunrise_reg);
        2:       base = (int'(sunrise_reg) + HourNoon) / 2;
        3:       base = HourNoon;
        4:       base = (int'(sunset_reg) + HourNoon) / 2;
        5:       base = int'(sunset_reg);
        6:       base = (int'(sunset_reg) + HourDay) / 2;
        default: base = HourDay;
      endcase
      base = base + $urandom_range(0, 8) - 4;
      hour = base + HourDay * ($urandom_range(0, 10) - 5);
      if (hour > 32767 || hour < -32768) hour = base;
    end
    for (int s = 0; s < NumSlots; s++) begin
      sel = $urandom_range(0, 9);
      col[s] = (sel == 0) ? '0 : (sel == 1) ? '1 : 24'($urandom());
    end
    return {16'(hour), col[0], col[1], col[2], col[3], col[4], col[5]};
  endfunction

  task automatic send_item(input tdci_in_t item, input tdci_out_t result);
    start_i <= 1'b1;
    data_i <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_colors = {pending_colors, result};
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CfgSunrise) sunrise_reg = value;
    else if (idx == CfgSunset) sunset_reg = value;
  endtask

  task automatic program_regs(input logic [CfgW-1:0] sr, input logic [CfgW-1:0] ss,
                              input bit with_spare);
    write_reg(CfgSunrise, sr);
    if (with_spare) write_reg(CfgSpareLo, 13'($urandom()));
    write_reg(CfgSunset, ss);
    if (with_spare) write_reg(CfgSpareHi, '1);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    tdci_out_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("ERROR: %0t: result with nothing outstanding: %h", $time, result_o);
      end else begin
        want = pending_colors.pop_front();
        if (result_o.red !== want.red || result_o.green !== want.green ||
            result_o.blue !== want.blue || result_o.from_slot !== want.from_slot ||
            result_o.to_slot !== want.to_slot ||
            result_o.blend_weight !== want.blend_weight) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display({"ERROR: %0t: expected rgb %h%h%h slots %0d->%0d weight %0d, ",
                      "got rgb %h%h%h slots %0d->%0d weight %0d"}, $time,
                     want.red, want.green, want.blue, want.from_slot, want.to_slot,
                     want.blend_weight, result_o.red, result_o.green, result_o.blue,
                     result_o.from_slot, result_o.to_slot, result_o.blend_weight);
        end
      end
    end
  end

  initial begin
    logic [CfgW-1:0] sr, ss;
    int              gap_pct;
    tdci_in_t        item;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      item = {DirTab[i].hour, SetColor[DirTab[i].cset][0], SetColor[DirTab[i].cset][1],
              SetColor[DirTab[i].cset][2], SetColor[DirTab[i].cset][3],
              SetColor[DirTab[i].cset][4], SetColor[DirTab[i].cset][5]};
      send_item(item, DirTab[i].known ? DirTab[i].result : blend_for_hour(item));
      sender_gap(25);
    end

    // Each phase starts with the pipeline empty, so the registers are quiet.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      if (p < NumFixedPhases) begin
        sr = PhaseSunrise[p];
        ss = PhaseSunset[p];
      end else if ($urandom_range(0, 1) == 1) begin
        sr = 13'($urandom_range(0, 8191));
        ss = 13'($urandom_range(0, 8191));
      end else begin
        sr = 13'($urandom_range(0, HourNoon));
        ss = 13'($urandom_range(HourNoon, HourDay));
      end
      program_regs(sr, ss, p % 3 == 2);
      if (p >= NumPhases - 2 || p % 3 == 1) gap_pct = 0;
      else gap_pct = $urandom_range(10, 50);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        item = draw_item();
        send_item(item, blend_for_hour(item));
        sender_gap(gap_pct);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
